// ===== hw/rtl/srsw_pkg.sv =====
// Shared types and constants for the selective-repeat sender window.
`default_nettype none

package srsw_pkg;

  // Default sizes of the sequence space and of the largest window
  localparam int SEQ_SPACE_DEF  = 64;
  localparam int MAX_WINDOW_DEF = 8;

  // Fixed port widths
  localparam int CMD_W      = 2;
  localparam int ACK_SEQ_W  = 6;
  localparam int SEQ_OUT_W  = 6;
  localparam int BASE_OUT_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int TOTAL_W    = 7;
  localparam int WINDOW_W   = 4;

  // Register reset values
  localparam logic [TOTAL_W-1:0]  TOTAL_RST  = 7'd10;
  localparam logic [WINDOW_W-1:0] WINDOW_RST = 4'd4;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

  // Event kinds; the spare code behaves as a send opportunity
  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_SPARE   = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLIDE_REQ,
    ST_SLIDE_CHK,
    ST_PREP,
    ST_WALK_REQ,
    ST_WALK_CHK,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/selective_repeat_sender_window_top.sv =====
// Selective-repeat ARQ sender window: sequencer, acked bitmap and result register.
//
//  Channel | Ports                                             | Direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid/in_ready, in_cmd, in_ack_seq             | word in
//  out     | out_valid/out_ready, out_seq, out_is_send,        | word out
//          | out_ack_ignored, out_done_res, out_base_now,      |
//          | out_last                                          |
//  cfg     | cfg_we, cfg_index, cfg_wdata                      | write only
//
// Steps: every word is accepted, the window edge is set, each sequence up to
//   the edge is walked with a bitmap read request and check, the walk ends and
//   the final word is given; an ack in range first slides the base over acked
//   entries, with a read request and check per slide step. At most one window is
//   walked; each walked entry takes its own read of the bitmap read port.
// Reset: rst_n is synchronous; afterwards the bitmap is swept clear, one entry
//   a cycle over all SEQ_SPACE entries, with in_ready low (cfg writes taken).
// Stalls: a held out word stops the sequencer, when it has a word to give, until
//   it is taken; a new in word is accepted while the last out word still waits.
`default_nettype none

module selective_repeat_sender_window_top
  import srsw_pkg::*;
#(
  parameter int SEQ_SPACE  = SEQ_SPACE_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  // event input
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [CMD_W-1:0]        in_cmd,
  input  wire  [ACK_SEQ_W-1:0]    in_ack_seq,
  // result output
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [SEQ_OUT_W-1:0]    out_seq,
  output logic                    out_is_send,
  output logic                    out_ack_ignored,
  output logic                    out_done_res,
  output logic [BASE_OUT_W-1:0]   out_base_now,
  output logic                    out_last,
  // configuration
  input  wire                     cfg_we,
  input  wire  [CFG_IDX_W-1:0]    cfg_index,
  input  wire  [CFG_DATA_W-1:0]   cfg_wdata
);

  // Bitmap address, and counters that must reach SEQ_SPACE itself
  localparam int IDX_W  = $clog2(SEQ_SPACE);
  localparam int CNT_W  = $clog2(SEQ_SPACE + 1);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
  localparam int WCMP_W = (WIN_W > WINDOW_W) ? WIN_W : WINDOW_W;
  localparam int EDGE_W = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [TOTAL_W-1:0]  total_r;
  logic [WINDOW_W-1:0] window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= TOTAL_RST;
      window_r <= WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL:  total_r  <= cfg_wdata[TOTAL_W-1:0];
        CFG_WINDOW: window_r <= cfg_wdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated total and window; config should only move while idle (the user's duty; the block does not enforce it)
  logic [CNT_W-1:0] tot;
  logic [WIN_W-1:0] win;

  always_comb begin
    if (CMP_W'(total_r) > CMP_W'(SEQ_SPACE)) tot = CNT_W'(SEQ_SPACE);
    else                                     tot = CNT_W'(total_r);
    if (WCMP_W'(window_r) > WCMP_W'(MAX_WINDOW)) win = WIN_W'(MAX_WINDOW);
    else                                         win = WIN_W'(window_r);
  end

  // ---------------------------------------------------------------------------
  // Acked bitmap: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic             acked_mem [SEQ_SPACE];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      acked_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= acked_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and window registers
  // ---------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0] next_r, next_nxt;
  logic [CNT_W-1:0] edge_r, edge_nxt;
  logic             done_r, done_nxt;
  logic             ign_r, ign_nxt;
  logic             held_r, held_nxt;       // a found send waits for its last flag
  logic [IDX_W-1:0] held_seq_r, held_seq_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [SEQ_OUT_W-1:0]  out_seq_r, out_seq_nxt;
  logic                  out_send_r, out_send_nxt;
  logic                  out_ign_r, out_ign_nxt;
  logic                  out_done_r, out_done_nxt;
  logic [BASE_OUT_W-1:0] out_base_r, out_base_nxt;
  logic                  out_last_r, out_last_nxt;

  // Handshake helpers
  logic             out_free;
  logic             in_fire;
  logic             ack_ok;
  logic             is_ack;
  logic             emit;
  logic [IDX_W-1:0] emit_seq;
  logic             emit_send;
  logic             emit_last;
  logic             step_ok;
  logic [EDGE_W-1:0] edge_sum;

  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_ack   = (cmd_t'(in_cmd) == CMD_ACK);
  assign ack_ok   = (CMP_W'(in_ack_seq) < CMP_W'(tot));
  assign step_ok  = !emit || out_free;
  assign edge_sum = EDGE_W'(base_r) + EDGE_W'(win);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == IDX_W'(SEQ_SPACE - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (is_ack && ack_ok) state_nxt = ST_SLIDE_REQ;
          else                  state_nxt = ST_PREP;
        end
      end
      ST_SLIDE_REQ: begin
        if (base_r < tot) state_nxt = ST_SLIDE_CHK;
        else              state_nxt = ST_PREP;
      end
      ST_SLIDE_CHK: begin
        if (mem_rdata_r) state_nxt = ST_SLIDE_REQ;
        else             state_nxt = ST_PREP;
      end
      ST_PREP: state_nxt = ST_WALK_REQ;
      ST_WALK_REQ: begin
        if (next_r < edge_r) state_nxt = ST_WALK_CHK;
        else                 state_nxt = ST_FINISH;
      end
      ST_WALK_CHK: begin
        if (step_ok) state_nxt = ST_WALK_REQ;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // State outputs: handshake, bitmap port, result to emit
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_idx_r;
    mem_wdata = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = base_r[IDX_W-1:0];
    emit      = 1'b0;
    emit_seq  = '0;
    emit_send = 1'b0;
    emit_last = 1'b0;
    unique case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && is_ack && ack_ok) begin
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(in_ack_seq);
          mem_wdata = 1'b1;
        end
      end
      ST_SLIDE_REQ: begin
        mem_re    = (base_r < tot);
        mem_raddr = base_r[IDX_W-1:0];
      end
      ST_WALK_REQ: begin
        mem_re    = (next_r < edge_r);
        mem_raddr = next_r[IDX_W-1:0];
      end
      ST_WALK_CHK: begin
        // a new unacked sequence releases the one held before it
        if (!mem_rdata_r && held_r) begin
          emit      = 1'b1;
          emit_seq  = held_seq_r;
          emit_send = 1'b1;
        end
      end
      ST_FINISH: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        if (held_r) begin
          emit_seq  = held_seq_r;
          emit_send = 1'b1;
        end
      end
      ST_SLIDE_CHK, ST_PREP: ;
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    edge_nxt      = edge_r;
    done_nxt      = done_r;
    ign_nxt       = ign_r;
    held_nxt      = held_r;
    held_seq_nxt  = held_seq_r;
    out_valid_nxt = out_valid_r;
    out_seq_nxt   = out_seq_r;
    out_send_nxt  = out_send_r;
    out_ign_nxt   = out_ign_r;
    out_done_nxt  = out_done_r;
    out_base_nxt  = out_base_r;
    out_last_nxt  = out_last_r;

    if (state_r == ST_CLEAR) clr_idx_nxt = clr_idx_r + 1'b1;

    if (state_r == ST_IDLE && in_fire) begin
      ign_nxt = is_ack && !ack_ok;
      if (cmd_t'(in_cmd) == CMD_TIMEOUT) next_nxt = base_r;
    end

    if (state_r == ST_SLIDE_CHK && mem_rdata_r) base_nxt = base_r + 1'b1;

    if (state_r == ST_PREP) begin
      if (next_r < base_r) next_nxt = base_r;
      done_nxt = (base_r >= tot);
      if (edge_sum > EDGE_W'(tot)) edge_nxt = tot;
      else                         edge_nxt = CNT_W'(edge_sum);
    end

    if (state_r == ST_WALK_CHK && step_ok) begin
      next_nxt = next_r + 1'b1;
      if (!mem_rdata_r) begin
        held_nxt     = 1'b1;
        held_seq_nxt = next_r[IDX_W-1:0];
      end
    end

    if (state_r == ST_FINISH && out_free) held_nxt = 1'b0;

    // result register
    if (emit && out_free) begin
      out_valid_nxt = 1'b1;
      out_seq_nxt   = SEQ_OUT_W'(emit_seq);
      out_send_nxt  = emit_send;
      out_ign_nxt   = ign_r;
      out_done_nxt  = done_r;
      out_base_nxt  = BASE_OUT_W'(base_r);
      out_last_nxt  = emit_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      base_r      <= '0;
      next_r      <= '0;
      held_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    edge_r     <= edge_nxt;
    done_r     <= done_nxt;
    ign_r      <= ign_nxt;
    held_seq_r <= held_seq_nxt;
    out_seq_r  <= out_seq_nxt;
    out_send_r <= out_send_nxt;
    out_ign_r  <= out_ign_nxt;
    out_done_r <= out_done_nxt;
    out_base_r <= out_base_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_seq         = out_seq_r;
  assign out_is_send     = out_send_r;
  assign out_ack_ignored = out_ign_r;
  assign out_done_res    = out_done_r;
  assign out_base_now    = out_base_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("input taken during bitmap clear");

  a_held_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (state_r == ST_WALK_REQ || state_r == ST_WALK_CHK ||
                state_r == ST_FINISH))
    else $error("held send outside the walk");

  a_next_not_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK_REQ || state_r == ST_WALK_CHK) |-> (next_r >= base_r))
    else $error("walk below window base");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_send_r) |-> (out_last_r && out_seq_r == '0))
    else $error("status word not final or carries a sequence");

  a_base_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR) |-> (base_r <= CNT_W'(SEQ_SPACE)))
    else $error("window base beyond sequence space");

endmodule

`default_nettype wire
